// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with a fixed message. The check is off while the
// synchronous reset is asserted.
`define ALKC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication check: when the trigger holds, the consequence holds in the next cycle.
`define ALKC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/alkc_pkg.sv
package alkc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int MODE_W  = 2;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

    // Request codes carried in the input tuser field.
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVALIDATE = 2'd2;

    // Register index of the slot count.
    localparam logic REG_ENTRIES = 1'b0;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_FILL  = 2'd1,
        WR_TOUCH = 2'd2,
        WR_CLEAR = 2'd3
    } t_wr_op;

    // Search record that travels down the row of slot cells.
    typedef struct packed {
        logic               active;
        logic               match_hit;
        logic [IDX_W-1:0]   match_idx;
        logic [VAL_W-1:0]   match_val;
        logic               free_hit;
        logic [IDX_W-1:0]   free_idx;
        logic               min_hit;
        logic [IDX_W-1:0]   min_idx;
        logic [STAMP_W-1:0] min_stamp;
    } t_rec;

    // Update broadcast to all cells when a request commits.
    typedef struct packed {
        t_wr_op             op;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage

// File: sv/alkc_cell.sv
module alkc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [alkc_pkg::IDX_W-1:0]    i_idx,
    input  logic                          i_en,
    input  logic [alkc_pkg::KEY_W-1:0]    i_key,
    input  alkc_pkg::t_rec                i_rec,
    output alkc_pkg::t_rec                o_rec,
    input  alkc_pkg::t_wr                 i_wr
);

    logic                           r_valid;
    logic [alkc_pkg::KEY_W-1:0]     r_key;
    logic [alkc_pkg::VAL_W-1:0]     r_value;
    logic [alkc_pkg::STAMP_W-1:0]   r_stamp;
    alkc_pkg::t_rec                 r_rec;
    alkc_pkg::t_rec                 n_rec;
    logic                           w_sel;

    assign w_sel = (i_wr.idx == i_idx);

    // Fold this slot into the passing record. Lower slots were seen first,
    // so a field already set is kept and ties go to the lower index.
    always_comb begin
        n_rec = i_rec;
        if (i_rec.active && i_en) begin
            if (r_valid && (r_key == i_key) && !i_rec.match_hit) begin
                n_rec.match_hit = 1'b1;
                n_rec.match_idx = i_idx;
                n_rec.match_val = r_value;
            end
            if (!r_valid && !i_rec.free_hit) begin
                n_rec.free_hit = 1'b1;
                n_rec.free_idx = i_idx;
            end
            if (!i_rec.min_hit || (r_stamp < i_rec.min_stamp)) begin
                n_rec.min_hit   = 1'b1;
                n_rec.min_idx   = i_idx;
                n_rec.min_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.active <= 1'b0;
        end else begin
            r_rec.active <= n_rec.active;
        end
        r_rec.match_hit <= n_rec.match_hit;
        r_rec.match_idx <= n_rec.match_idx;
        r_rec.match_val <= n_rec.match_val;
        r_rec.free_hit  <= n_rec.free_hit;
        r_rec.free_idx  <= n_rec.free_idx;
        r_rec.min_hit   <= n_rec.min_hit;
        r_rec.min_idx   <= n_rec.min_idx;
        r_rec.min_stamp <= n_rec.min_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (w_sel) begin
            unique case (i_wr.op)
                alkc_pkg::WR_FILL: begin
                    r_valid <= 1'b1;
                    r_stamp <= i_wr.stamp;
                end
                alkc_pkg::WR_TOUCH: begin
                    r_stamp <= i_wr.stamp;
                end
                alkc_pkg::WR_CLEAR: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && (i_wr.op == alkc_pkg::WR_FILL)) begin
            r_key   <= i_wr.key;
            r_value <= i_wr.value;
        end
    end

    assign o_rec = r_rec;

endmodule

// File: sv/assoc_lru_key_cache_core.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: mode; tdata: key, value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: hit, found_value, evicted, slot
// apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata (slot count)
//
// One request is handled at a time and the next is accepted only after the commit:
// a search record walks the row of slot cells, one cell per cycle, then it is
// captured and the request commits.
// Reset is synchronous and active low; it clears all valid bits, stamps, the
// use counter and the handshakes, and sets the slot count to 16.
// A stalled result is held in the output register; the commit waits for it.
module assoc_lru_key_cache_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [63:0] key, [95:64] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] hit, [32:1] found_value,
                                        // [33] evicted, [37:34] slot, rest zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state                                 r_state;
    t_state                                 n_state;

    // Request held for the whole search.
    logic [alkc_pkg::MODE_W-1:0]            r_mode;
    logic [alkc_pkg::KEY_W-1:0]             r_key;
    logic [alkc_pkg::VAL_W-1:0]             r_value;
    logic                                   r_go;

    logic [alkc_pkg::CFG_W-1:0]             r_entries;
    logic [alkc_pkg::STAMP_W-1:0]           r_cnt;
    alkc_pkg::t_rec                         r_rec;

    logic                                   r_ovalid;
    logic                                   r_hit;
    logic [alkc_pkg::VAL_W-1:0]             r_found;
    logic                                   r_evicted;
    logic [alkc_pkg::SLOT_W-1:0]            r_slot;

    logic                                   w_accept;
    logic                                   w_cfg_wr;
    logic                                   w_fire;
    logic [alkc_pkg::STAMP_W-1:0]           w_next_stamp;

    // Commit decisions.
    alkc_pkg::t_wr_op                       c_op;
    logic [alkc_pkg::IDX_W-1:0]             c_idx;
    logic                                   c_bump;
    logic                                   c_hit;
    logic [alkc_pkg::VAL_W-1:0]             c_found;
    logic                                   c_evicted;
    alkc_pkg::t_wr                          w_wr;

    // Row of cells: w_chain[i] enters cell i, w_chain[CAPACITY] leaves the row.
    alkc_pkg::t_rec                         w_head;
    alkc_pkg::t_rec                         w_chain [alkc_pkg::CAPACITY+1];
    logic [alkc_pkg::CAPACITY-1:0]          w_en;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // ---------------------------------------------------------------------
    // Configuration port. Only the slot count exists, at every address with paddr[2]
    // low; addresses with paddr[2] high read as zero and ignore writes.
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == alkc_pkg::REG_ENTRIES);
    assign prdata   = (paddr[2] == alkc_pkg::REG_ENTRIES) ? 32'(r_entries) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= alkc_pkg::ENTRIES_RESET;
        end else if (w_cfg_wr) begin
            r_entries <= pwdata[alkc_pkg::CFG_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Cell row. Slot 0 always takes part, so a count of zero acts as one;
    // counts above the capacity simply enable every cell.
    // ---------------------------------------------------------------------
    always_comb begin
        w_head        = '0;
        w_head.active = r_go;
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < alkc_pkg::CAPACITY; g++) begin : g_cell
        assign w_en[g] = (g == 0) || (g < int'(r_entries));

        alkc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (alkc_pkg::IDX_W'(g)),
            .i_en    (w_en[g]),
            .i_key   (r_key),
            .i_rec   (w_chain[g]),
            .o_rec   (w_chain[g+1]),
            .i_wr    (w_wr)
        );
    end

    // ---------------------------------------------------------------------
    // Controller.
    // ---------------------------------------------------------------------
    assign w_fire = (r_state == ST_COMMIT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_chain[alkc_pkg::CAPACITY].active) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_fire) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= s_axis_tuser;
            r_key   <= s_axis_tdata[63:0];
            r_value <= s_axis_tdata[95:64];
        end
        if ((r_state == ST_SCAN) && w_chain[alkc_pkg::CAPACITY].active) begin
            r_rec <= w_chain[alkc_pkg::CAPACITY];
        end
    end

    // ---------------------------------------------------------------------
    // Commit: decide the slot update and the result from the finished record.
    // An insert takes the first free slot, else the oldest one.
    // ---------------------------------------------------------------------
    assign w_next_stamp = r_cnt + alkc_pkg::STAMP_W'(1);

    always_comb begin
        c_op      = alkc_pkg::WR_NONE;
        c_idx     = '0;
        c_bump    = 1'b0;
        c_hit     = 1'b0;
        c_found   = '0;
        c_evicted = 1'b0;
        unique case (r_mode)
            alkc_pkg::MODE_LOOKUP: begin
                if (r_rec.match_hit) begin
                    c_op    = alkc_pkg::WR_TOUCH;
                    c_idx   = r_rec.match_idx;
                    c_bump  = 1'b1;
                    c_hit   = 1'b1;
                    c_found = r_rec.match_val;
                end
            end
            alkc_pkg::MODE_INSERT: begin
                c_op      = alkc_pkg::WR_FILL;
                c_idx     = r_rec.free_hit ? r_rec.free_idx : r_rec.min_idx;
                c_bump    = 1'b1;
                c_evicted = !r_rec.free_hit;
            end
            alkc_pkg::MODE_INVALIDATE: begin
                if (r_rec.match_hit) begin
                    c_op  = alkc_pkg::WR_CLEAR;
                    c_idx = r_rec.match_idx;
                    c_hit = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_wr.op    = w_fire ? c_op : alkc_pkg::WR_NONE;
        w_wr.idx   = c_idx;
        w_wr.key   = r_key;
        w_wr.value = r_value;
        w_wr.stamp = w_next_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_fire && c_bump) begin
            r_cnt <= w_next_stamp;
        end
    end

    // ---------------------------------------------------------------------
    // Output register.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_fire) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit     <= c_hit;
            r_found   <= c_found;
            r_evicted <= c_evicted;
            r_slot    <= (c_op == alkc_pkg::WR_NONE) ? '0 : alkc_pkg::SLOT_W'(c_idx);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_slot, r_evicted, r_found, r_hit};

    // ---------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------
`include "assert_macros.svh"

    `ALKC_ASSERT_NEXT(a_accept_starts_scan, w_accept, (r_state == ST_SCAN) && r_go, "no scan")
    `ALKC_ASSERT_NEXT(a_commit_gives_result, w_fire, m_axis_tvalid, "no result after commit")
    `ALKC_ASSERT(a_hit_xor_evict, !(m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[33]), "hit+evict")
    `ALKC_ASSERT_NEXT(a_idle_counter, !(w_fire && c_bump), $stable(r_cnt), "counter moved")

endmodule
